>>> hw/rtl/mrfb_pkg.sv
// Package for the meter report frame builder.
// Holds the widths, frame constants, byte positions and the command type.
// It depends on nothing else.
package mrfb_pkg;

  localparam int MAX_RECORDS = 16;

  localparam int ADDR_W      = 48;
  localparam int BYTE_W      = 8;
  localparam int RL_W        = $clog2(MAX_RECORDS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W       = 5;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_BIT = 3;

  localparam logic REG_DEST = 1'b0;

  localparam logic [BYTE_W-1:0] SOF_BYTE  = 8'h68;
  localparam logic [BYTE_W-1:0] CTRL_BYTE = 8'h91;
  localparam logic [BYTE_W-1:0] DI_BYTE   = 8'hAC;
  localparam logic [BYTE_W-1:0] OFFSET    = 8'h33;
  localparam logic [BYTE_W-1:0] EOF_BYTE  = 8'h16;
  localparam logic [BYTE_W-1:0] LEN_BASE  = 8'd5;
  localparam logic [BYTE_W-1:0] REC_BYTES = 8'd7;

  localparam logic [POS_W-1:0] POS_START  = 5'd0;
  localparam logic [POS_W-1:0] POS_DEST   = 5'd1;
  localparam logic [POS_W-1:0] POS_DEST_E = 5'd6;
  localparam logic [POS_W-1:0] POS_SOF2   = 5'd7;
  localparam logic [POS_W-1:0] POS_CTRL   = 5'd8;
  localparam logic [POS_W-1:0] POS_LEN    = 5'd9;
  localparam logic [POS_W-1:0] POS_DI     = 5'd10;
  localparam logic [POS_W-1:0] POS_DI_E   = 5'd13;
  localparam logic [POS_W-1:0] POS_CNT    = 5'd14;
  localparam logic [POS_W-1:0] POS_REC    = 5'd15;
  localparam logic [POS_W-1:0] POS_REC_E  = 5'd20;
  localparam logic [POS_W-1:0] POS_PROTO  = 5'd21;
  localparam logic [POS_W-1:0] POS_SUM    = 5'd22;
  localparam logic [POS_W-1:0] POS_END    = 5'd23;

  typedef struct packed {
    logic [ADDR_W-1:0] maddr;
    logic [BYTE_W-1:0] proto;
    logic [BYTE_W-1:0] count;
    logic              first;
    logic              last;
    logic              err;
  } mrfb_cmd_t;

endpackage

>>> hw/rtl/mrfb_in_if.sv
// Input channel of the meter report frame builder: one meter record per request.
// Depends on mrfb_pkg.
interface mrfb_in_if import mrfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] meter_address;
  logic [BYTE_W-1:0] protocol_code;
  logic [BYTE_W-1:0] meter_count;

  modport source (output valid, meter_address, protocol_code, meter_count, input ready);
  modport sink (input valid, meter_address, protocol_code, meter_count, output ready);
endinterface

>>> hw/rtl/mrfb_out_if.sv
// Result channel of the meter report frame builder: one frame byte per request.
// Depends on mrfb_pkg.
interface mrfb_out_if import mrfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;
  logic              count_error;

  modport source (output valid, frame_byte, last_byte, count_error, input ready);
  modport sink (input valid, frame_byte, last_byte, count_error, output ready);
endinterface

>>> hw/rtl/meter_report_frame_builder.sv
// Top level of the meter report frame builder: configuration port and the three parts.
// Depends on mrfb_pkg, mrfb_in_if, mrfb_out_if, mrfb_front, mrfb_queue and mrfb_back.
//
// Each accepted meter record produces one frame byte per cycle, while out_ch is ready:
// seven bytes per record, plus fifteen header bytes on the first record of a frame and
// the checksum and end byte on the last one, and a single byte for a rejected count.
// The one-byte result channel sets this rate; records are taken into a two-entry queue
// while earlier bytes are still going out. The destination address register sits at
// byte address 0 and may only be written while no frame bytes are pending.
module meter_report_frame_builder import mrfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mrfb_in_if.sink               in_ch,
  mrfb_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [ADDR_W-1:0] dest_r;
  logic              q_full;
  logic              q_push;
  mrfb_cmd_t         q_cmd;
  logic              q_pop;
  logic              q_valid;
  mrfb_cmd_t         q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_IDX_BIT] == REG_DEST) ?
                      CFG_DATA_W'(dest_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[CFG_IDX_BIT] == REG_DEST) begin
      dest_r <= cfg_pwdata[ADDR_W-1:0];
    end
  end

  mrfb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  mrfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  mrfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_addr  (dest_r),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

>>> hw/rtl/mrfb_front.sv
// Front part: accepts meter records, tracks the open frame and classifies each record.
// Depends on mrfb_pkg and mrfb_in_if.
module mrfb_front import mrfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mrfb_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        q_push,
  output mrfb_cmd_t   q_cmd
);

  logic            in_frame_r;
  logic [RL_W-1:0] records_left_r;
  logic            in_frame_nxt;
  logic [RL_W-1:0] records_left_nxt;
  logic            bad_count;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    bad_count        = (in_ch.meter_count == 8'd0) ||
                       (in_ch.meter_count > 8'(MAX_RECORDS));
    in_frame_nxt     = in_frame_r;
    records_left_nxt = records_left_r;
    q_cmd.maddr      = in_ch.meter_address;
    q_cmd.proto      = in_ch.protocol_code;
    q_cmd.count      = in_ch.meter_count;
    q_cmd.first      = 1'b0;
    q_cmd.err        = 1'b0;
    if (!in_frame_r) begin
      q_cmd.err        = bad_count;
      q_cmd.first      = !bad_count;
      records_left_nxt = RL_W'(in_ch.meter_count - 8'd1);
    end else begin
      records_left_nxt = records_left_r - RL_W'(1);
    end
    q_cmd.last = (records_left_nxt == '0);
    if (!q_cmd.err) begin
      in_frame_nxt = !q_cmd.last;
    end else begin
      records_left_nxt = records_left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r     <= 1'b0;
      records_left_r <= '0;
    end else if (q_push) begin
      in_frame_r     <= in_frame_nxt;
      records_left_r <= records_left_nxt;
    end
  end

  a_open_frame_has_records: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> records_left_r != '0)
    else $error("Open frame with no records left.");

endmodule

>>> hw/rtl/mrfb_queue.sv
// Short command queue between the front and back parts.
// Depends on mrfb_pkg.
module mrfb_queue import mrfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mrfb_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output mrfb_cmd_t head_cmd
);

  mrfb_cmd_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("Push into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("Pop from an empty queue.");

endmodule

>>> hw/rtl/mrfb_back.sv
// Back part: turns queued commands into frame bytes and keeps the running checksum.
// Depends on mrfb_pkg and mrfb_out_if.
module mrfb_back import mrfb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] dest_addr,
  input  logic              head_valid,
  input  mrfb_cmd_t         head_cmd,
  output logic              pop,
  mrfb_out_if.source        out_ch
);

  mrfb_cmd_t         cmd_r;
  logic              busy_r;
  logic [POS_W-1:0]  pos_r;
  logic [BYTE_W-1:0] sum_r;
  logic              ov_r;
  logic [BYTE_W-1:0] ob_r;
  logic              ol_r;
  logic              oe_r;

  logic              adv;
  logic              last_pos;
  logic [2:0]        dest_sel;
  logic [2:0]        rec_sel;
  logic [BYTE_W-1:0] byte_nxt;
  logic [BYTE_W-1:0] sum_nxt;

  assign adv      = busy_r && (!ov_r || out_ch.ready);
  assign last_pos = cmd_r.err || (pos_r == POS_END) || (pos_r == POS_PROTO && !cmd_r.last);
  assign pop      = head_valid && (!busy_r || (adv && last_pos));
  assign dest_sel = 3'(pos_r - POS_DEST);
  assign rec_sel  = 3'(pos_r - POS_REC);

  always_comb begin
    case (pos_r) inside
      POS_START, POS_SOF2:     byte_nxt = SOF_BYTE;
      [POS_DEST:POS_DEST_E]:   byte_nxt = dest_addr[{dest_sel, 3'b000} +: BYTE_W];
      POS_CTRL:                byte_nxt = CTRL_BYTE;
      POS_LEN:                 byte_nxt = LEN_BASE + REC_BYTES * cmd_r.count;
      [POS_DI:POS_DI_E]:       byte_nxt = DI_BYTE + OFFSET;
      POS_CNT:                 byte_nxt = cmd_r.count + OFFSET;
      [POS_REC:POS_REC_E]:     byte_nxt = cmd_r.maddr[{rec_sel, 3'b000} +: BYTE_W] + OFFSET;
      POS_PROTO:               byte_nxt = cmd_r.proto + OFFSET;
      POS_SUM:                 byte_nxt = sum_r;
      POS_END:                 byte_nxt = EOF_BYTE;
      default:                 byte_nxt = '0;
    endcase
    sum_nxt = ((pos_r == POS_START) ? '0 : sum_r) + byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
    if (adv) begin
      ob_r <= cmd_r.err ? '0 : byte_nxt;
      ol_r <= cmd_r.err || (pos_r == POS_END);
      oe_r <= cmd_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_START;
      sum_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        pos_r  <= head_cmd.first ? POS_START : POS_REC;
      end else if (adv && last_pos) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        pos_r <= pos_r + POS_W'(1);
      end
      if (adv && !cmd_r.err && pos_r < POS_SUM) begin
        sum_r <= sum_nxt;
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.frame_byte  = ob_r;
  assign out_ch.last_byte   = ol_r;
  assign out_ch.count_error = oe_r;

  a_record_skips_header: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !cmd_r.first && !cmd_r.err |-> pos_r >= POS_REC)
    else $error("Continuation record entered the header.");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r <= POS_END)
    else $error("Byte position past the end byte.");

endmodule
